FILE: rtl/core/mpsic_pkg.sv
// Shared types and constants of the MIPS subset integer core.
package mpsic_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_NOR  = 6'd39;
   localparam logic [5:0] FN_SLTU = 6'd43;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_WINDOW  = 2'd1;
   localparam logic [1:0] FAULT_ALIGN   = 2'd2;

   localparam logic [0:0] CSR_TEXT_START = 1'b0;
   localparam logic [0:0] CSR_DATA_BASE  = 1'b1;

   localparam logic [31:0] SEG_MASK  = 32'hF000_0000;
   localparam logic [4:0]  LINK_REG  = 5'd31;
   localparam int          LUI_SHIFT = 16;

   localparam logic [31:0] TEXT_START_RESET = 32'h0040_0000;
   localparam logic [31:0] DATA_BASE_RESET  = 32'h1000_0000;

   typedef struct packed {
      logic        wr;
      logic [4:0]  dst;
      logic [31:0] val;
      logic        ld_ok;
      logic        mwr;
      logic [31:0] maddr;
      logic [31:0] mdata;
      logic [1:0]  fault;
      logic [31:0] npc;
      logic [31:0] off;
   } exec_result_type;

endpackage

FILE: rtl/core/mpsic_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mpsic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mpsic_exec.sv
// Execute unit: decodes one instruction and computes its results and next PC.
module mpsic_exec #(
   parameter int DMEM_WORDS = 1024
) (
   input  logic [31:0]                    instr,
   input  logic [31:0]                    pc,
   input  logic [31:0]                    a,
   input  logic [31:0]                    b,
   input  logic [31:0]                    data_base,
   output mpsic_pkg::exec_result_type     res
);

   localparam logic [31:0] WinBytes = 32'(4 * DMEM_WORDS);

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [31:0] imm;
   logic [31:0] simm;
   logic [31:0] pc4;
   logic [31:0] maddr;
   logic [32:0] diff;
   logic        in_win;
   logic        wr_raw;
   logic [4:0]  dst_raw;
   logic [31:0] val_raw;
   logic        ld_raw;
   logic        st_raw;

   assign op    = instr[31:26];
   assign fn    = instr[5:0];
   assign rt    = instr[20:16];
   assign rd    = instr[15:11];
   assign sh    = instr[10:6];
   assign imm   = {16'd0, instr[15:0]};
   assign simm  = {{16{instr[15]}}, instr[15:0]};
   assign pc4   = pc + 32'd4;
   assign maddr = a + simm;
   assign diff  = {1'b0, maddr} - {1'b0, data_base};
   assign in_win = !diff[32] && (diff[31:0] < WinBytes);

   always_comb begin
      wr_raw  = 1'b0;
      dst_raw = 5'd0;
      val_raw = 32'd0;
      ld_raw  = 1'b0;
      st_raw  = 1'b0;
      res     = '0;
      res.npc = pc4;
      unique case (op) inside
         mpsic_pkg::OP_SPECIAL: begin
            unique case (fn)
               mpsic_pkg::FN_SLL:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = b << sh; end
               mpsic_pkg::FN_SRL:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = b >> sh; end
               mpsic_pkg::FN_JR:   res.npc = a;
               mpsic_pkg::FN_ADDU: begin wr_raw = 1'b1; dst_raw = rd; val_raw = a + b; end
               mpsic_pkg::FN_SUBU: begin wr_raw = 1'b1; dst_raw = rd; val_raw = a - b; end
               mpsic_pkg::FN_AND:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = a & b; end
               mpsic_pkg::FN_OR:   begin wr_raw = 1'b1; dst_raw = rd; val_raw = a | b; end
               mpsic_pkg::FN_NOR:  begin wr_raw = 1'b1; dst_raw = rd; val_raw = ~(a | b); end
               mpsic_pkg::FN_SLTU: begin
                  wr_raw = 1'b1; dst_raw = rd; val_raw = {31'd0, a < b};
               end
               default: ;
            endcase
         end
         mpsic_pkg::OP_J, mpsic_pkg::OP_JAL: begin
            res.npc = (pc4 & mpsic_pkg::SEG_MASK) | {4'd0, instr[25:0], 2'b00};
            if (op == mpsic_pkg::OP_JAL) begin
               wr_raw = 1'b1; dst_raw = mpsic_pkg::LINK_REG; val_raw = pc4;
            end
         end
         mpsic_pkg::OP_BEQ, mpsic_pkg::OP_BNE: begin
            if ((op == mpsic_pkg::OP_BEQ) == (a == b)) begin
               res.npc = pc4 + {simm[29:0], 2'b00};
            end
         end
         mpsic_pkg::OP_ADDIU: begin wr_raw = 1'b1; dst_raw = rt; val_raw = a + simm; end
         mpsic_pkg::OP_SLTIU: begin
            wr_raw = 1'b1; dst_raw = rt; val_raw = {31'd0, a < simm};
         end
         mpsic_pkg::OP_ANDI: begin wr_raw = 1'b1; dst_raw = rt; val_raw = a & imm; end
         mpsic_pkg::OP_ORI:  begin wr_raw = 1'b1; dst_raw = rt; val_raw = a | imm; end
         mpsic_pkg::OP_LUI:  begin
            wr_raw = 1'b1; dst_raw = rt; val_raw = imm << mpsic_pkg::LUI_SHIFT;
         end
         mpsic_pkg::OP_LW, mpsic_pkg::OP_SW: begin
            res.maddr = maddr;
            res.off   = diff[31:0];
            if (!in_win) begin
               res.fault = mpsic_pkg::FAULT_WINDOW;
            end else if (maddr[1:0] != 2'b00) begin
               res.fault = mpsic_pkg::FAULT_ALIGN;
            end else if (op == mpsic_pkg::OP_LW) begin
               ld_raw = 1'b1; wr_raw = 1'b1; dst_raw = rt;
            end else begin
               st_raw = 1'b1;
            end
         end
         default: ;
      endcase
      res.ld_ok = ld_raw;
      res.mwr   = st_raw;
      res.mdata = st_raw ? b : 32'd0;
      if (wr_raw && (dst_raw != 5'd0)) begin
         res.wr  = 1'b1;
         res.dst = dst_raw;
         res.val = val_raw;
      end
   end

endmodule

FILE: rtl/core/mips_subset_integer_core.sv
// Top level of the MIPS subset integer core: pipeline, state memories and ports.
//
// The core executes one instruction word per transfer and returns one result
// transfer for each, at a sustained rate of one instruction per clock cycle
// while the result side does not stall; an instruction passes through the
// execute stage, the memory stage and the output register. The register file
// sits in two 32-entry RAMs (one per source operand) read when the instruction
// is taken, and the data memory is a DMEM_WORDS-entry RAM read and written in
// the execute cycle. Dependences between neighbouring instructions, loads
// included, are resolved by forwarding, so no dependence stalls the pipeline.
// After reset the data memory is cleared one word per cycle; during that pass
// no instruction is taken, though register writes on the configuration port
// are accepted. Writing text_start also moves the PC.
module mips_subset_integer_core #(
   parameter int DMEM_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_instr_pc,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_num,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_write,
   output logic [31:0] rsp_mem_addr,
   output logic [31:0] rsp_mem_data,
   output logic [1:0]  rsp_fault,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int AddrWidth = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
   localparam logic [AddrWidth-1:0] LastWord = AddrWidth'(DMEM_WORDS - 1);

   // The pipeline moves as a whole whenever the output register can take a result.
   logic move;
   logic accept;

   // Clearing pass over the data memory.
   logic                 clr_ff;
   logic [AddrWidth-1:0] clr_cnt_ff;

   logic [31:0] pc_ff;
   logic [31:0] data_base_ff;

   // Execute stage.
   logic        s1_v_ff;
   logic [31:0] s1_instr_ff;
   logic        a_vld_ff;
   logic        b_vld_ff;
   logic [31:0] a_ram;
   logic [31:0] b_ram;
   logic [31:0] a_op;
   logic [31:0] b_op;
   logic [4:0]  s1_rs;
   logic [4:0]  s1_rt;
   mpsic_pkg::exec_result_type ex_res;

   // Register valid bits: an entry never written reads as zero.
   logic [31:0] rf_valid_ff;

   // Bypass of the register write made at the edge where the execute stage was loaded.
   logic        byp_v_ff;
   logic [4:0]  byp_num_ff;
   logic [31:0] byp_val_ff;

   // Memory stage.
   logic        s2_v_ff;
   logic [31:0] s2_pc_ff;
   mpsic_pkg::exec_result_type s2_res_ff;
   logic [31:0] dmem_rdata;
   logic [31:0] s2_val;
   logic [31:0] s2_mdata;

   logic                 rf_we;
   logic                 dmem_we;
   logic [AddrWidth-1:0] dmem_waddr;
   logic [31:0]          dmem_wdata;
   logic [AddrWidth-1:0] dmem_idx;

   // Output register.
   logic        out_v_ff;
   logic [31:0] out_pc_ff;
   logic [31:0] out_npc_ff;
   logic        out_rw_ff;
   logic [4:0]  out_rn_ff;
   logic [31:0] out_rv_ff;
   logic        out_mw_ff;
   logic [31:0] out_ma_ff;
   logic [31:0] out_md_ff;
   logic [1:0]  out_flt_ff;

   assign move      = !out_v_ff || rsp_ready;
   assign req_ready = move && !clr_ff;
   assign accept    = req_valid && req_ready;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         byp_v_ff    <= 1'b0;
         rf_valid_ff <= '0;
         pc_ff       <= mpsic_pkg::TEXT_START_RESET;
         data_base_ff <= mpsic_pkg::DATA_BASE_RESET;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LastWord) begin
               clr_ff <= 1'b0;
            end
         end
         if (move) begin
            s1_v_ff  <= accept;
            s2_v_ff  <= s1_v_ff;
            out_v_ff <= s2_v_ff;
            byp_v_ff <= rf_we;
            if (s1_v_ff) begin
               pc_ff <= ex_res.npc;
            end
         end
         if (rf_we) begin
            rf_valid_ff[s2_res_ff.dst] <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               mpsic_pkg::CSR_TEXT_START: pc_ff        <= csr_wr_data;
               mpsic_pkg::CSR_DATA_BASE:  data_base_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr_word;
         a_vld_ff    <= rf_valid_ff[req_instr_word[25:21]];
         b_vld_ff    <= rf_valid_ff[req_instr_word[20:16]];
      end
      if (move) begin
         byp_num_ff <= s2_res_ff.dst;
         byp_val_ff <= s2_val;
         s2_pc_ff   <= pc_ff;
         s2_res_ff  <= ex_res;
         out_pc_ff  <= s2_pc_ff;
         out_npc_ff <= s2_res_ff.npc;
         out_rw_ff  <= s2_res_ff.wr;
         out_rn_ff  <= s2_res_ff.dst;
         out_rv_ff  <= s2_val;
         out_mw_ff  <= s2_res_ff.mwr;
         out_ma_ff  <= s2_res_ff.maddr;
         out_md_ff  <= s2_mdata;
         out_flt_ff <= s2_res_ff.fault;
      end
   end

   // Register file: both copies take every write, each serves one source operand.
   assign rf_we = move && s2_v_ff && s2_res_ff.wr;

   mpsic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (s2_res_ff.dst),
      .wr_data (s2_val),
      .rd_en   (accept),
      .rd_addr (req_instr_word[25:21]),
      .rd_data (a_ram)
   );

   mpsic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (s2_res_ff.dst),
      .wr_data (s2_val),
      .rd_en   (accept),
      .rd_addr (req_instr_word[20:16]),
      .rd_data (b_ram)
   );

   // Operand forwarding: the instruction ahead wins, then the write made as
   // this one was taken, then the RAM copy.
   assign s1_rs = s1_instr_ff[25:21];
   assign s1_rt = s1_instr_ff[20:16];

   always_comb begin
      if (s2_v_ff && s2_res_ff.wr && (s2_res_ff.dst == s1_rs)) begin
         a_op = s2_val;
      end else if (byp_v_ff && (byp_num_ff == s1_rs)) begin
         a_op = byp_val_ff;
      end else begin
         a_op = a_vld_ff ? a_ram : 32'd0;
      end
      if (s2_v_ff && s2_res_ff.wr && (s2_res_ff.dst == s1_rt)) begin
         b_op = s2_val;
      end else if (byp_v_ff && (byp_num_ff == s1_rt)) begin
         b_op = byp_val_ff;
      end else begin
         b_op = b_vld_ff ? b_ram : 32'd0;
      end
   end

   mpsic_exec #(.DMEM_WORDS(DMEM_WORDS)) u_exec (
      .instr     (s1_instr_ff),
      .pc        (pc_ff),
      .a         (a_op),
      .b         (b_op),
      .data_base (data_base_ff),
      .res       (ex_res)
   );

   // Data memory: stores and loads are both issued as the instruction leaves execute.
   assign dmem_idx   = ex_res.off[AddrWidth+1:2];
   assign dmem_we    = clr_ff || (move && s1_v_ff && ex_res.mwr);
   assign dmem_waddr = clr_ff ? clr_cnt_ff : dmem_idx;
   assign dmem_wdata = clr_ff ? 32'd0 : ex_res.mdata;

   mpsic_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dmem_we),
      .wr_addr (dmem_waddr),
      .wr_data (dmem_wdata),
      .rd_en   (move && s1_v_ff && ex_res.ld_ok),
      .rd_addr (dmem_idx),
      .rd_data (dmem_rdata)
   );

   assign s2_val   = (s2_res_ff.ld_ok && s2_res_ff.wr) ? dmem_rdata : s2_res_ff.val;
   assign s2_mdata = s2_res_ff.ld_ok ? dmem_rdata : s2_res_ff.mdata;

   assign rsp_valid     = out_v_ff;
   assign rsp_instr_pc  = out_pc_ff;
   assign rsp_next_pc   = out_npc_ff;
   assign rsp_reg_write = out_rw_ff;
   assign rsp_reg_num   = out_rn_ff;
   assign rsp_reg_value = out_rv_ff;
   assign rsp_mem_write = out_mw_ff;
   assign rsp_mem_addr  = out_ma_ff;
   assign rsp_mem_data  = out_md_ff;
   assign rsp_fault     = out_flt_ff;

   // No instruction may be taken while the data memory is still being cleared.
   assert property (@(posedge clock) disable iff (reset) clr_ff |-> !req_ready)
      else $error("instruction taken during data memory clearing");

   // A stalled pipeline must leave the architectural state untouched.
   assert property (@(posedge clock) disable iff (reset)
      (!move && !clr_ff) |-> (!dmem_we && !rf_we))
      else $error("state written while pipeline stalled");

   // Register zero is never written.
   assert property (@(posedge clock) disable iff (reset) rf_we |-> (s2_res_ff.dst != 5'd0))
      else $error("write to register zero");

   // A faulting access never writes memory or a register.
   assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && (s2_res_ff.fault != mpsic_pkg::FAULT_NONE)) |->
      (!s2_res_ff.wr && !s2_res_ff.mwr))
      else $error("faulting access has side effects");

endmodule

FILE: tb/mips_subset_integer_core_test.sv
// Self-checking testbench of the MIPS subset integer core: directed table, random programs.
module mips_subset_integer_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DMEM_WORDS = 1024;
   // Generous bound: clearing pass plus every item meeting long gaps and stalls.
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 460;
   localparam logic [4:0] BASE_REG = 5'd28;

   typedef struct packed {
      logic [31:0] instr_pc;
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  reg_num;
      logic [31:0] reg_value;
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [31:0] mem_data;
      logic [1:0]  fault;
   } retire_type;

   typedef struct {
      logic [31:0] word;
      bit          typed;
      retire_type  result;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_instr_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_instr_pc;
   logic [31:0] rsp_next_pc;
   logic        rsp_reg_write;
   logic [4:0]  rsp_reg_num;
   logic [31:0] rsp_reg_value;
   logic        rsp_mem_write;
   logic [31:0] rsp_mem_addr;
   logic [31:0] rsp_mem_data;
   logic [1:0]  rsp_fault;
   logic        csr_wr_en;
   logic [0:0]  csr_index;
   logic [31:0] csr_wr_data;

   // Architectural shadow of the core, advanced once per accepted instruction.
   logic [31:0] shadow_data_base;
   logic [31:0] shadow_pc;
   logic [31:0] shadow_regs [32];
   logic [31:0] shadow_dmem [DMEM_WORDS];

   retire_type   pending_retires [$];
   logic [31:0]  program_words [$];
   stim_row_type directed_rows [$];
   int          fail_count;
   int          tick_total;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          random_sent;

   mips_subset_integer_core #(
      .DMEM_WORDS(DMEM_WORDS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_instr_word(req_instr_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_instr_pc  (rsp_instr_pc),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_reg_write (rsp_reg_write),
      .rsp_reg_num   (rsp_reg_num),
      .rsp_reg_value (rsp_reg_value),
      .rsp_mem_write (rsp_mem_write),
      .rsp_mem_addr  (rsp_mem_addr),
      .rsp_mem_data  (rsp_mem_data),
      .rsp_fault     (rsp_fault),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // The watchdog ends a run that has hung somewhere.
   always @(posedge clock) begin
      tick_total <= tick_total + 1;
      if (tick_total > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] r_ins(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
      return {mpsic_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_ins(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic retire_type mk_retire(logic [31:0] pc, logic [31:0] npc, logic wr,
                                            logic [4:0] num, logic [31:0] val, logic mwr,
                                            logic [31:0] addr, logic [31:0] data,
                                            logic [1:0] flt);
      retire_type r;
      r.instr_pc  = pc;
      r.next_pc   = npc;
      r.reg_write = wr;
      r.reg_num   = num;
      r.reg_value = val;
      r.mem_write = mwr;
      r.mem_addr  = addr;
      r.mem_data  = data;
      r.fault     = flt;
      return r;
   endfunction

   // Executes one instruction on the shadow state and returns what it should retire as.
   task automatic execute_instr(input logic [31:0] w, output retire_type r);
      logic [5:0]  op;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [5:0]  fn;
      logic [31:0] imm;
      logic [31:0] simm;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] pc4;
      logic [31:0] off;
      logic        wr;
      logic [4:0]  dst;
      logic [31:0] val;
      op   = w[31:26];
      rs   = w[25:21];
      rt   = w[20:16];
      rd   = w[15:11];
      sh   = w[10:6];
      fn   = w[5:0];
      imm  = {16'h0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a    = shadow_regs[rs];
      b    = shadow_regs[rt];
      pc4  = shadow_pc + 32'd4;
      wr   = 1'b0;
      dst  = 5'd0;
      val  = 32'd0;
      r = mk_retire(shadow_pc, pc4, 1'b0, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0,
                    mpsic_pkg::FAULT_NONE);
      case (op)
         mpsic_pkg::OP_SPECIAL: begin
            case (fn)
               mpsic_pkg::FN_SLL:  begin wr = 1'b1; dst = rd; val = b << sh; end
               mpsic_pkg::FN_SRL:  begin wr = 1'b1; dst = rd; val = b >> sh; end
               mpsic_pkg::FN_JR:   r.next_pc = a;
               mpsic_pkg::FN_ADDU: begin wr = 1'b1; dst = rd; val = a + b; end
               mpsic_pkg::FN_SUBU: begin wr = 1'b1; dst = rd; val = a - b; end
               mpsic_pkg::FN_AND:  begin wr = 1'b1; dst = rd; val = a & b; end
               mpsic_pkg::FN_OR:   begin wr = 1'b1; dst = rd; val = a | b; end
               mpsic_pkg::FN_NOR:  begin wr = 1'b1; dst = rd; val = ~(a | b); end
               mpsic_pkg::FN_SLTU: begin wr = 1'b1; dst = rd; val = {31'd0, a < b}; end
               default: ;
            endcase
         end
         mpsic_pkg::OP_J, mpsic_pkg::OP_JAL: begin
            r.next_pc = (pc4 & mpsic_pkg::SEG_MASK) | {4'd0, w[25:0], 2'b00};
            if (op == mpsic_pkg::OP_JAL) begin
               wr = 1'b1; dst = mpsic_pkg::LINK_REG; val = pc4;
            end
         end
         mpsic_pkg::OP_BEQ, mpsic_pkg::OP_BNE: begin
            if ((op == mpsic_pkg::OP_BEQ) == (a == b))
               r.next_pc = pc4 + (simm << 2);
         end
         mpsic_pkg::OP_ADDIU: begin wr = 1'b1; dst = rt; val = a + simm; end
         mpsic_pkg::OP_SLTIU: begin wr = 1'b1; dst = rt; val = {31'd0, a < simm}; end
         mpsic_pkg::OP_ANDI:  begin wr = 1'b1; dst = rt; val = a & imm; end
         mpsic_pkg::OP_ORI:   begin wr = 1'b1; dst = rt; val = a | imm; end
         mpsic_pkg::OP_LUI:   begin wr = 1'b1; dst = rt; val = imm << mpsic_pkg::LUI_SHIFT; end
         mpsic_pkg::OP_LW, mpsic_pkg::OP_SW: begin
            r.mem_addr = a + simm;
            off = r.mem_addr - shadow_data_base;
            // The window test comes first; alignment only matters inside it.
            if (r.mem_addr < shadow_data_base || off >= DMEM_WORDS * 4)
               r.fault = mpsic_pkg::FAULT_WINDOW;
            else if (r.mem_addr[1:0] != 2'b00)
               r.fault = mpsic_pkg::FAULT_ALIGN;
            else if (op == mpsic_pkg::OP_LW) begin
               r.mem_data = shadow_dmem[off >> 2];
               wr = 1'b1; dst = rt; val = r.mem_data;
            end else begin
               shadow_dmem[off >> 2] = b;
               r.mem_data  = b;
               r.mem_write = 1'b1;
            end
         end
         default: ;
      endcase
      if (wr && dst != 5'd0) begin
         shadow_regs[dst] = val;
         r.reg_write = 1'b1;
         r.reg_num   = dst;
         r.reg_value = val;
      end
      shadow_pc = r.next_pc;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // Result side: random stalls, and every transfer compared with the oldest expectation.
   always @(posedge clock) begin
      retire_type want;
      if (!reset) begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_retires.size() == 0) begin
               $error("result transfer with no instruction outstanding, pc %h", rsp_instr_pc);
               fail_count++;
            end else begin
               want = pending_retires.pop_front();
               check_field("instr_pc", want.instr_pc, rsp_instr_pc);
               check_field("next_pc", want.next_pc, rsp_next_pc);
               check_field("reg_write", 32'(want.reg_write), 32'(rsp_reg_write));
               check_field("reg_num", 32'(want.reg_num), 32'(rsp_reg_num));
               check_field("reg_value", want.reg_value, rsp_reg_value);
               check_field("mem_write", 32'(want.mem_write), 32'(rsp_mem_write));
               check_field("mem_addr", want.mem_addr, rsp_mem_addr);
               check_field("mem_data", want.mem_data, rsp_mem_data);
               check_field("fault", 32'(want.fault), 32'(rsp_fault));
            end
         end
      end
   end

   // Presents one instruction and holds it until its transfer; a typed row overrides
   // the shadow's prediction, though the shadow still executes it.
   task automatic send_instr(input logic [31:0] w, input bit typed, input retire_type typed_res);
      retire_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         if (req_valid) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         while ($urandom_range(0, 99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_instr_word <= w;
      do
         @(posedge clock);
      while (!req_ready);
      execute_instr(w, predicted);
      pending_retires.push_back(typed ? typed_res : predicted);
   endtask

   // Stops sending and waits until every outstanding result has been seen,
   // then lets the pipeline drain.
   task automatic drain_core();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_retires.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes both configuration registers on consecutive cycles.
   task automatic write_config(input logic [31:0] text_start, input logic [31:0] data_base);
      csr_wr_en   <= 1'b1;
      csr_index   <= mpsic_pkg::CSR_TEXT_START;
      csr_wr_data <= text_start;
      @(posedge clock);
      csr_index   <= mpsic_pkg::CSR_DATA_BASE;
      csr_wr_data <= data_base;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_pc         = text_start;
      shadow_data_base  = data_base;
   endtask

   function automatic logic [4:0] pick_dest();
      logic [4:0] d;
      d = 5'($urandom_range(0, 31));
      // The base pointer is kept intact by well-formed code.
      return (d == BASE_REG) ? 5'd27 : d;
   endfunction

   function automatic logic [4:0] pick_reg();
      return 5'($urandom_range(0, 31));
   endfunction

   // Appends the next piece of a random program: mostly well-formed instructions,
   // loads and stores aimed at the data window through the base pointer.
   task automatic generate_program();
      logic [5:0]  alu_fns [8];
      logic [5:0]  imm_ops [5];
      logic [5:0]  op;
      logic [4:0]  rs;
      logic [15:0] off;
      int          kind;
      alu_fns = '{mpsic_pkg::FN_SLL, mpsic_pkg::FN_SRL, mpsic_pkg::FN_ADDU,
                  mpsic_pkg::FN_SUBU, mpsic_pkg::FN_AND, mpsic_pkg::FN_OR,
                  mpsic_pkg::FN_NOR, mpsic_pkg::FN_SLTU};
      imm_ops = '{mpsic_pkg::OP_ADDIU, mpsic_pkg::OP_SLTIU, mpsic_pkg::OP_ANDI,
                  mpsic_pkg::OP_ORI, mpsic_pkg::OP_LUI};
      kind = $urandom_range(0, 15);
      if (kind <= 5)
         program_words.push_back(r_ins(pick_reg(), pick_reg(), pick_dest(),
                                       5'($urandom), alu_fns[$urandom_range(0, 7)]));
      else if (kind <= 8)
         program_words.push_back(i_ins(imm_ops[$urandom_range(0, 4)], pick_reg(),
                                       pick_dest(), 16'($urandom)));
      else if (kind <= 11) begin
         if (shadow_regs[BASE_REG] != shadow_data_base) begin
            program_words.push_back(i_ins(mpsic_pkg::OP_LUI, 5'd0, BASE_REG,
                                          shadow_data_base[31:16]));
            program_words.push_back(i_ins(mpsic_pkg::OP_ORI, BASE_REG, BASE_REG,
                                          shadow_data_base[15:0]));
         end else begin
            op  = $urandom_range(0, 1) ? mpsic_pkg::OP_LW : mpsic_pkg::OP_SW;
            rs  = ($urandom_range(0, 7) == 0) ? pick_reg() : BASE_REG;
            off = 16'($urandom_range(0, DMEM_WORDS - 1) * 4);
            case ($urandom_range(0, 7))
               0: off = off + 16'($urandom_range(1, 3));
               1: off = $urandom_range(0, 1) ? 16'(DMEM_WORDS * 4) : 16'hFFFC;
               default: ;
            endcase
            program_words.push_back(i_ins(op, rs,
                                          (op == mpsic_pkg::OP_LW) ? pick_dest() : pick_reg(),
                                          off));
         end
      end else if (kind == 12) begin
         rs = pick_reg();
         program_words.push_back(i_ins($urandom_range(0, 1) ? mpsic_pkg::OP_BEQ
                                                              : mpsic_pkg::OP_BNE, rs,
                                       $urandom_range(0, 1) ? rs : pick_reg(), 16'($urandom)));
      end else if (kind == 13) begin
         case ($urandom_range(0, 2))
            0: program_words.push_back({mpsic_pkg::OP_J, 26'($urandom)});
            1: program_words.push_back({mpsic_pkg::OP_JAL, 26'($urandom)});
            default: program_words.push_back(r_ins(pick_reg(), 5'd0, 5'd0, 5'd0,
                                                   mpsic_pkg::FN_JR));
         endcase
      end else if (kind == 14)
         program_words.push_back($urandom);
      else
         program_words.push_back(r_ins(pick_reg(), pick_reg(), pick_dest(), 5'($urandom),
                                       6'($urandom_range(0, 63))));
   endtask

   task automatic add_row(input logic [31:0] w, input bit typed, input retire_type res);
      stim_row_type row;
      row.word   = w;
      row.typed  = typed;
      row.result = res;
      directed_rows.push_back(row);
   endtask

   // Directed table. The first rows run straight after reset and their results are
   // plain to see; the rest go through the shadow predictor.
   task automatic build_directed();
      retire_type none;
      none = '0;
      // A nop as the very first instruction, at the reset text address.
      add_row(32'h0000_0000, 1'b1, mk_retire(32'h0040_0000, 32'h0040_0004, 1'b0, 5'd0, 32'd0,
                                             1'b0, 32'd0, 32'd0, mpsic_pkg::FAULT_NONE));
      // A load from address zero lies below the window.
      add_row(i_ins(mpsic_pkg::OP_LW, 5'd0, 5'd5, 16'h0000), 1'b1,
              mk_retire(32'h0040_0004, 32'h0040_0008, 1'b0, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0,
                        mpsic_pkg::FAULT_WINDOW));
      add_row(i_ins(mpsic_pkg::OP_LUI, 5'd0, BASE_REG, 16'h1000), 1'b1,
              mk_retire(32'h0040_0008, 32'h0040_000C, 1'b1, BASE_REG, 32'h1000_0000, 1'b0,
                        32'd0, 32'd0, mpsic_pkg::FAULT_NONE));
      // Unaligned load inside the window.
      add_row(i_ins(mpsic_pkg::OP_LW, BASE_REG, 5'd5, 16'h0001), 1'b1,
              mk_retire(32'h0040_000C, 32'h0040_0010, 1'b0, 5'd0, 32'd0, 1'b0, 32'h1000_0001,
                        32'd0, mpsic_pkg::FAULT_ALIGN));
      // Last word of the window, still zero from the clearing pass.
      add_row(i_ins(mpsic_pkg::OP_LW, BASE_REG, 5'd5, 16'h0FFC), 1'b1,
              mk_retire(32'h0040_0010, 32'h0040_0014, 1'b1, 5'd5, 32'd0, 1'b0, 32'h1000_0FFC,
                        32'd0, mpsic_pkg::FAULT_NONE));
      // A store just past the end of the window.
      add_row(i_ins(mpsic_pkg::OP_SW, BASE_REG, 5'd0, 16'h1000), 1'b1,
              mk_retire(32'h0040_0014, 32'h0040_0018, 1'b0, 5'd0, 32'd0, 1'b0, 32'h1000_1000,
                        32'd0, mpsic_pkg::FAULT_WINDOW));
      add_row(i_ins(mpsic_pkg::OP_ADDIU, 5'd0, 5'd1, 16'hFFFF), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h0001), 1'b0, none);
      add_row(r_ins(5'd1, 5'd2, 5'd3, 5'd0, mpsic_pkg::FN_ADDU), 1'b0, none);
      add_row(r_ins(5'd0, 5'd2, 5'd4, 5'd0, mpsic_pkg::FN_SUBU), 1'b0, none);
      add_row(r_ins(5'd1, 5'd2, 5'd5, 5'd0, mpsic_pkg::FN_AND), 1'b0, none);
      add_row(r_ins(5'd1, 5'd2, 5'd6, 5'd0, mpsic_pkg::FN_OR), 1'b0, none);
      add_row(r_ins(5'd0, 5'd0, 5'd7, 5'd0, mpsic_pkg::FN_NOR), 1'b0, none);
      add_row(r_ins(5'd2, 5'd1, 5'd8, 5'd0, mpsic_pkg::FN_SLTU), 1'b0, none);
      add_row(r_ins(5'd0, 5'd1, 5'd9, 5'd31, mpsic_pkg::FN_SLL), 1'b0, none);
      add_row(r_ins(5'd0, 5'd1, 5'd10, 5'd31, mpsic_pkg::FN_SRL), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_SLTIU, 5'd2, 5'd11, 16'hFFFF), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_ANDI, 5'd1, 5'd12, 16'hFFFF), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_ORI, 5'd0, 5'd13, 16'h8000), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_LUI, 5'd0, 5'd14, 16'hFFFF), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_SW, BASE_REG, 5'd1, 16'h0FFC), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_LW, BASE_REG, 5'd15, 16'h0FFC), 1'b0, none);
      // Writing r0 must leave no trace.
      add_row(r_ins(5'd1, 5'd1, 5'd0, 5'd0, mpsic_pkg::FN_ADDU), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_BEQ, 5'd1, 5'd1, 16'h8000), 1'b0, none);
      add_row(i_ins(mpsic_pkg::OP_BNE, 5'd1, 5'd2, 16'h7FFF), 1'b0, none);
      add_row({mpsic_pkg::OP_JAL, 26'h3FF_FFFF}, 1'b0, none);
      add_row(r_ins(5'd1, 5'd0, 5'd0, 5'd0, mpsic_pkg::FN_JR), 1'b0, none);
      // Unknown opcode.
      add_row(32'hFFFF_FFFF, 1'b0, none);
   endtask

   initial begin
      logic [31:0] phase_text [4];
      logic [31:0] phase_data [4];
      retire_type  none;
      none           = '0;
      fail_count     = 0;
      random_sent    = 0;
      send_idle_pct  = 30;
      recv_stall_pct = 57;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_instr_word = 32'd0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = mpsic_pkg::CSR_TEXT_START;
      csr_wr_data    = 32'd0;
      shadow_data_base  = mpsic_pkg::DATA_BASE_RESET;
      shadow_pc         = mpsic_pkg::TEXT_START_RESET;
      foreach (shadow_regs[i]) shadow_regs[i] = 32'd0;
      foreach (shadow_dmem[i]) shadow_dmem[i] = 32'd0;
      // Phase zero keeps the reset values; then both extremes and one random setting.
      phase_text = '{mpsic_pkg::TEXT_START_RESET, 32'h0000_0000, 32'hFFFF_FFFC, 32'd0};
      phase_data = '{mpsic_pkg::DATA_BASE_RESET, 32'h0000_0000, 32'hFFFF_FFFC, 32'd0};
      phase_text[3] = {30'($urandom), 2'b00};
      phase_data[3] = {30'($urandom), 2'b00};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      build_directed();
      foreach (directed_rows[i])
         send_instr(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
      // Let the pipeline run dry once before the random programs start.
      drain_core();

      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) begin
            drain_core();
            write_config(phase_text[ph], phase_data[ph]);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Idling pattern follows overall progress through the random part.
            if (random_sent < 613) begin
               send_idle_pct = 30; recv_stall_pct = 57;
            end else if (random_sent < 1226) begin
               send_idle_pct = 57; recv_stall_pct = 30;
            end else begin
               send_idle_pct = 0; recv_stall_pct = 0;
            end
            if (program_words.size() == 0)
               generate_program();
            send_instr(program_words.pop_front(), 1'b0, none);
            random_sent++;
         end
      end

      drain_core();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
